@@ design/assert_macros.svh @@
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge, skip while in reset.
`define AST_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every clock edge, reset included.
`define AST_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/ntoe_pkg.sv @@
`default_nettype none
package ntoe_pkg;

  localparam int MAX_NODES = 32;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int ENTRY_W   = 6;

  localparam logic [2:0] OP_HEARD   = 3'd0;
  localparam logic [2:0] OP_LOOKUP  = 3'd1;
  localparam logic [2:0] OP_LOOKIDX = 3'd2;
  localparam logic [2:0] OP_SETFAV  = 3'd3;
  localparam logic [2:0] OP_SETIGN  = 3'd4;
  localparam logic [2:0] OP_REMOVE  = 3'd5;
  localparam logic [2:0] OP_RESET   = 3'd6;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_REJECT   = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic              ignored;
    logic              favorite;
    logic [2:0]        hop_dist;
    logic              hops_known;
    logic              mqtt;
    logic [7:0]        nhop;
    logic [2:0]        channel;
    logic signed [7:0] snr;
    logic [31:0]       heard;
  } info_t;

  localparam int INFO_W = $bits(info_t);

endpackage
`default_nettype wire

@@ design/node_table_with_oldest_eviction_unit.sv @@
`default_nettype none
// Neighbor table of MAX_NODES records held in two RAMs with registered reads
// (ids and record info). One operation at a time: operations that search by
// id (heard, lookup by id, flag updates, remove) scan the used slots one per
// cycle, then read the slot found; heard and flag updates write it back and
// remove moves the last record into the gap. A miss or a drop on a full
// table ends after the scan. Lookup by index reads its slot without a scan;
// table reset, rejected senders and unknown operations go straight to the
// result. The result is held until taken, then the next item is accepted.
// No clearing pass after reset.
`include "assert_macros.svh"
module node_table_with_oldest_eviction_unit import ntoe_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [31:0]       cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [2:0]        operation,
  input  wire logic [31:0]       node_id,
  input  wire logic [31:0]       now_sec,
  input  wire logic signed [7:0] snr_db,
  input  wire logic [2:0]        channel_number,
  input  wire logic              channel_valid,
  input  wire logic [7:0]        relay_hop,
  input  wire logic              came_via_mqtt,
  input  wire logic [2:0]        hop_limit_start,
  input  wire logic [2:0]        hop_left,
  input  wire logic              flag_value,
  input  wire logic [4:0]        slot_index,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             status,
  output logic [31:0]            found_id,
  output logic [31:0]            heard_time,
  output logic signed [7:0]      stored_snr,
  output logic [2:0]             stored_channel,
  output logic [7:0]             stored_next_hop,
  output logic                   mqtt_flag,
  output logic                   hops_known,
  output logic [2:0]             hop_distance,
  output logic                   favorite_flag,
  output logic                   ignored_flag,
  output logic [ENTRY_W-1:0]     entries_used
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_SCAN = 8'b0000_0010,
    S_RD   = 8'b0000_0100,
    S_RDW  = 8'b0000_1000,
    S_RDL  = 8'b0001_0000,
    S_RDLW = 8'b0010_0000,
    S_WR   = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  state_t state;

  logic [31:0]       local_id;
  logic [CNT_W-1:0]  used_count;

  // latched beat
  logic [2:0]        op_q;
  logic [31:0]       id_q;
  logic [31:0]       now_q;
  logic [7:0]        snr_q;
  logic [2:0]        chan_q;
  logic [7:0]        nh_q;
  logic              mqtt_q;
  logic [2:0]        hs_q;
  logic [2:0]        hl_q;
  logic              flag_q;

  // scan
  logic [CNT_W-1:0]  issue_cnt;
  logic              chk_valid;
  logic [IDX_W-1:0]  chk_addr;
  logic              match_found;
  logic [IDX_W-1:0]  match_idx;
  logic              best_valid;
  logic [IDX_W-1:0]  best_idx;
  logic [31:0]       best_time;

  logic [IDX_W-1:0]  idx;
  logic              is_new;
  logic [31:0]       old_id;
  info_t             old_info;

  logic [1:0]        res_status;
  logic [31:0]       res_id;
  info_t             res_info;

  // decision taken at accept
  state_t            acc_state;
  logic [1:0]        acc_status;
  logic [31:0]       acc_id;
  info_t             acc_info;

  // RAM ports
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [IDX_W-1:0]  raddr;
  logic [31:0]       wid;
  info_t             winfo;
  logic [31:0]       rd_id;
  logic [INFO_W-1:0] rd_raw;
  info_t             rd_info;

  assign rd_info = info_t'(rd_raw);

  ntoe_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_ids (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wid), .raddr(raddr), .rdata(rd_id)
  );

  ntoe_ram #(.WIDTH(INFO_W), .DEPTH(MAX_NODES)) u_info (
    .clk(clk), .we(we), .waddr(waddr), .wdata(winfo), .raddr(raddr), .rdata(rd_raw)
  );

  logic       scan_more;
  logic       scan_done;
  logic       hops_ok;
  info_t      heard_info;
  info_t      mod_info;
  logic [CNT_W-1:0] last_slot;

  assign scan_more = issue_cnt < used_count;
  assign scan_done = !scan_more && !chk_valid;
  assign hops_ok   = (hs_q != 3'd0) && (hs_q >= hl_q);
  assign last_slot = used_count - CNT_W'(1);

  always_comb begin
    heard_info = is_new ? info_t'('0) : old_info;
    if (hops_ok) begin
      heard_info.hops_known = 1'b1;
      heard_info.hop_dist   = hs_q - hl_q;
    end
    heard_info.heard    = now_q;
    heard_info.snr      = snr_q;
    heard_info.channel  = chan_q;
    heard_info.nhop     = nh_q;
    heard_info.mqtt     = mqtt_q;

    mod_info = old_info;
    if (op_q == OP_SETFAV) begin
      mod_info.favorite = flag_q;
    end else begin
      mod_info.ignored = flag_q;
    end
  end

  always_comb begin
    acc_state  = S_OUT;
    acc_status = ST_REJECT;
    acc_id     = '0;
    acc_info   = '0;
    case (operation)
      OP_HEARD: begin
        if (node_id != 32'd0 && node_id != local_id) acc_state = S_SCAN;
      end
      OP_LOOKUP, OP_SETFAV, OP_SETIGN: acc_state = S_SCAN;
      OP_REMOVE: begin
        if (node_id != local_id) acc_state = S_SCAN;
      end
      OP_LOOKIDX: begin
        if (32'(slot_index) < 32'(used_count)) begin
          acc_state = S_RD;
        end else begin
          acc_status = ST_NOTFOUND;
        end
      end
      OP_RESET: begin
        if (local_id != 32'd0) begin
          acc_status     = ST_OK;
          acc_id         = local_id;
          acc_info.heard = now_sec;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wid   = id_q;
    winfo = heard_info;
    raddr = idx;
    case (state)
      S_IDLE: begin
        waddr = '0;
        wid   = local_id;
        winfo = '0;
        winfo.heard = now_sec;
        we    = in_valid && (operation == OP_RESET) && (local_id != 32'd0);
      end
      S_SCAN: raddr = issue_cnt[IDX_W-1:0];
      S_RDL:  raddr = last_slot[IDX_W-1:0];
      S_RDLW: begin
        we    = 1'b1;
        wid   = rd_id;
        winfo = rd_info;
      end
      S_WR: begin
        we    = (op_q == OP_HEARD) || (op_q == OP_SETFAV) || (op_q == OP_SETIGN);
        winfo = (op_q == OP_HEARD) ? heard_info : mod_info;
      end
      default: ;
    endcase
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      local_id   <= '0;
      used_count <= '0;
      chk_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        local_id <= cfg_wdata;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q        <= operation;
            id_q        <= node_id;
            now_q       <= now_sec;
            snr_q       <= snr_db;
            chan_q      <= channel_valid ? channel_number : 3'd0;
            nh_q        <= relay_hop;
            mqtt_q      <= came_via_mqtt;
            hs_q        <= hop_limit_start;
            hl_q        <= hop_left;
            flag_q      <= flag_value;
            is_new      <= 1'b0;
            issue_cnt   <= '0;
            chk_valid   <= 1'b0;
            match_found <= 1'b0;
            best_valid  <= 1'b0;
            idx         <= IDX_W'(slot_index);
            res_status  <= acc_status;
            res_id      <= acc_id;
            res_info    <= acc_info;
            state       <= acc_state;
            if (operation == OP_RESET) begin
              used_count <= (local_id != 32'd0) ? CNT_W'(1) : '0;
            end
          end
        end
        S_SCAN: begin
          chk_valid <= scan_more;
          chk_addr  <= issue_cnt[IDX_W-1:0];
          if (scan_more) begin
            issue_cnt <= issue_cnt + CNT_W'(1);
          end
          if (chk_valid) begin
            if (rd_id == id_q && !match_found) begin
              match_found <= 1'b1;
              match_idx   <= chk_addr;
            end
            if (rd_id != local_id && !rd_info.favorite &&
                (!best_valid || rd_info.heard < best_time)) begin
              best_valid <= 1'b1;
              best_idx   <= chk_addr;
              best_time  <= rd_info.heard;
            end
          end
          if (scan_done) begin
            if (match_found) begin
              idx   <= match_idx;
              state <= S_RD;
            end else if (op_q != OP_HEARD) begin
              res_status <= ST_NOTFOUND;
              state      <= S_OUT;
            end else if (used_count < CNT_W'(MAX_NODES)) begin
              idx        <= used_count[IDX_W-1:0];
              used_count <= used_count + CNT_W'(1);
              is_new     <= 1'b1;
              state      <= S_RD;
            end else if (best_valid) begin
              idx    <= best_idx;
              is_new <= 1'b1;
              state  <= S_RD;
            end else begin
              res_status <= ST_FULL;
              state      <= S_OUT;
            end
          end
        end
        S_RD: state <= S_RDW;
        S_RDW: begin
          old_id   <= rd_id;
          old_info <= rd_info;
          state    <= (op_q == OP_REMOVE) ? S_RDL : S_WR;
        end
        S_RDL: state <= S_RDLW;
        S_RDLW: begin
          // move last record into the gap
          used_count <= last_slot;
          res_status <= ST_OK;
          res_id     <= old_id;
          res_info   <= old_info;
          state      <= S_OUT;
        end
        S_WR: begin
          res_status <= ST_OK;
          res_id     <= (op_q == OP_HEARD) ? id_q : old_id;
          case (op_q)
            OP_HEARD:            res_info <= heard_info;
            OP_SETFAV, OP_SETIGN: res_info <= mod_info;
            default:             res_info <= old_info;
          endcase
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign status          = res_status;
  assign found_id        = res_id;
  assign heard_time      = res_info.heard;
  assign stored_snr      = res_info.snr;
  assign stored_channel  = res_info.channel;
  assign stored_next_hop = res_info.nhop;
  assign mqtt_flag       = res_info.mqtt;
  assign hops_known      = res_info.hops_known;
  assign hop_distance    = res_info.hop_dist;
  assign favorite_flag   = res_info.favorite;
  assign ignored_flag    = res_info.ignored;
  assign entries_used    = ENTRY_W'(used_count);

  `AST_CLK(a_count_bound, used_count <= CNT_W'(MAX_NODES), "used count beyond table size")
  `AST_CLK(a_one_side, !(in_ready && out_valid), "input taken while result pending")
  `AST_CLK(a_out_done, out_valid && out_ready |=> in_ready, "no return to idle after beat")
  `AST_CLK(a_fail_zero, out_valid && status != ST_OK |-> found_id == 32'd0,
           "failed result carries an id")

endmodule
`default_nettype wire

@@ design/ntoe_ram.sv @@
`default_nettype none
module ntoe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
